/* hdl/decimal_string_to_fixed_point_assert.svh */
// assertion macros shared by the parser modules
`ifndef DECIMAL_STRING_TO_FIXED_POINT_ASSERT_SVH
`define DECIMAL_STRING_TO_FIXED_POINT_ASSERT_SVH

`ifndef ASSERT_OFF

// cond must hold at every edge out of reset
`define DSFP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// cons must hold in the same cycle as ante
`define DSFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`else

`define DSFP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DSFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/dsfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dsfp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int CNT_W   = 5;
    localparam int DIGIT_W = 4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SCALE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SCALE     = 1'd1;

    localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // largest value that can still be multiplied by ten in 64 bits
    localparam logic [VALUE_W-1:0] MUL10_LIMIT = 64'd1844674407370955161;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } char_beat_t;

    typedef struct packed {
        logic               accepted;
        logic [VALUE_W-1:0] result_value;
        logic [CNT_W-1:0]   fraction_digits;
    } res_beat_t;

    typedef struct packed {
        logic             fixed_scale_mode;
        logic [CNT_W-1:0] target_scale;
    } cfg_t;

    // one finished string handed from front to back
    typedef struct packed {
        logic               rejected;
        logic [VALUE_W-1:0] mantissa;
        logic [CNT_W-1:0]   frac_count;
    } str_rec_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

/* hdl/dsfp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_string_to_fixed_point_assert.svh"

module dsfp_front #(
    parameter int MAX_LENGTH  = 22,
    parameter int DIGIT_LIMIT = 20
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                char_valid,
    output logic                     char_ready,
    input  wire dsfp_pkg::char_beat_t char_data,
    input  wire dsfp_pkg::q_status_t q_status,
    output logic                     push,
    output dsfp_pkg::str_rec_t       push_rec
);

    logic [dsfp_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [dsfp_pkg::CNT_W-1:0]   digit_cnt_reg, digit_cnt_next;
    logic [dsfp_pkg::CNT_W-1:0]   frac_cnt_reg, frac_cnt_next;
    logic [dsfp_pkg::CNT_W-1:0]   char_cnt_reg, char_cnt_next;
    logic                         dot_reg, dot_next;
    logic                         rej_reg, rej_next;

    logic                         fire;
    logic                         first;
    logic [dsfp_pkg::DIGIT_W-1:0] digit;
    logic [dsfp_pkg::CNT_W-1:0]   digit_cnt_inc;
    logic [dsfp_pkg::VALUE_W-1:0] acc_times10;

    assign char_ready    = !q_status.full;
    assign fire          = char_valid && char_ready;
    assign first         = (char_cnt_reg == '0);
    assign digit         = dsfp_pkg::DIGIT_W'(char_data.character - dsfp_pkg::CHAR_ZERO);
    assign digit_cnt_inc = dsfp_pkg::CNT_W'(digit_cnt_reg + 1'b1);
    assign acc_times10   = dsfp_pkg::VALUE_W'((acc_reg << 3) + (acc_reg << 1));

    always_comb
    begin
        acc_next       = acc_reg;
        digit_cnt_next = digit_cnt_reg;
        frac_cnt_next  = frac_cnt_reg;
        char_cnt_next  = char_cnt_reg;
        dot_next       = dot_reg;
        rej_next       = rej_reg;
        if (!rej_reg)
        begin
            if (char_cnt_reg >= dsfp_pkg::CNT_W'(MAX_LENGTH))
            begin
                rej_next = 1'b1;
            end
            else
            begin
                char_cnt_next = dsfp_pkg::CNT_W'(char_cnt_reg + 1'b1);
                if (char_data.character inside {[dsfp_pkg::CHAR_ZERO:dsfp_pkg::CHAR_NINE]})
                begin
                    digit_cnt_next = digit_cnt_inc;
                    if (digit_cnt_inc >= dsfp_pkg::CNT_W'(DIGIT_LIMIT))
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = dsfp_pkg::VALUE_W'(acc_times10
                                   + dsfp_pkg::VALUE_W'(digit));
                        if (dot_reg)
                        begin
                            frac_cnt_next = dsfp_pkg::CNT_W'(frac_cnt_reg + 1'b1);
                        end
                    end
                end
                else if (char_data.character == dsfp_pkg::CHAR_DOT)
                begin
                    // fraction restarts at every dot
                    dot_next      = 1'b1;
                    frac_cnt_next = '0;
                end
                else if (!(char_data.character == dsfp_pkg::CHAR_PLUS && first))
                begin
                    rej_next = 1'b1;
                end
            end
        end
    end

    assign push                = fire && char_data.last_char;
    assign push_rec.rejected   = rej_next;
    assign push_rec.mantissa   = acc_next;
    assign push_rec.frac_count = frac_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            digit_cnt_reg <= '0;
            frac_cnt_reg  <= '0;
            char_cnt_reg  <= '0;
            dot_reg       <= 1'b0;
            rej_reg       <= 1'b0;
        end
        else if (fire)
        begin
            if (char_data.last_char)
            begin
                acc_reg       <= '0;
                digit_cnt_reg <= '0;
                frac_cnt_reg  <= '0;
                char_cnt_reg  <= '0;
                dot_reg       <= 1'b0;
                rej_reg       <= 1'b0;
            end
            else
            begin
                acc_reg       <= acc_next;
                digit_cnt_reg <= digit_cnt_next;
                frac_cnt_reg  <= frac_cnt_next;
                char_cnt_reg  <= char_cnt_next;
                dot_reg       <= dot_next;
                rej_reg       <= rej_next;
            end
        end
    end

    `DSFP_ASSERT_ALWAYS(a_char_cnt_bound, clk, rst_n, char_cnt_reg <= dsfp_pkg::CNT_W'(MAX_LENGTH))
    `DSFP_ASSERT_ALWAYS(a_digit_cnt_bound, clk, rst_n, digit_cnt_reg <= dsfp_pkg::CNT_W'(DIGIT_LIMIT))
    `DSFP_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, q_status.full, !push)

endmodule

`default_nettype wire

/* hdl/dsfp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_string_to_fixed_point_assert.svh"

module dsfp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dsfp_pkg::str_rec_t push_rec,
    input  wire logic               pop,
    output dsfp_pkg::str_rec_t      head_rec,
    output dsfp_pkg::q_status_t     q_status
);

    dsfp_pkg::str_rec_t            entry_reg [dsfp_pkg::QUEUE_DEPTH];
    logic [dsfp_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dsfp_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dsfp_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == dsfp_pkg::QCNT_W'(dsfp_pkg::QUEUE_DEPTH));
    assign head_rec       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dsfp_pkg::QPTR_W'(dsfp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : dsfp_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dsfp_pkg::QPTR_W'(dsfp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : dsfp_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = dsfp_pkg::QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = dsfp_pkg::QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DSFP_ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, q_status.empty, !pop)
    `DSFP_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= dsfp_pkg::QCNT_W'(dsfp_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

/* hdl/dsfp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_string_to_fixed_point_assert.svh"

module dsfp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dsfp_pkg::cfg_t      cfg,
    input  wire dsfp_pkg::q_status_t q_status,
    input  wire dsfp_pkg::str_rec_t  head_rec,
    output logic                     pop,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output dsfp_pkg::res_beat_t      res_data
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SCALE = 2'b10
    } back_state_t;

    back_state_t                  state_reg, state_next;
    logic [dsfp_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [dsfp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         ok_reg, ok_next;
    logic                         out_valid_reg, out_valid_next;
    dsfp_pkg::res_beat_t          out_reg, out_next;

    logic                         slot_free;
    logic                         direct;
    logic                         direct_ok;
    logic                         load_out;

    assign slot_free = !out_valid_reg || res_ready;
    assign direct    = head_rec.rejected || !cfg.fixed_scale_mode
                       || (head_rec.frac_count >= cfg.target_scale);
    assign direct_ok = !head_rec.rejected
                       && !(cfg.fixed_scale_mode && (head_rec.frac_count > cfg.target_scale));

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        ok_next    = ok_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        out_next   = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (direct)
                    begin
                        if (slot_free)
                        begin
                            pop                      = 1'b1;
                            load_out                 = 1'b1;
                            out_next.accepted        = direct_ok;
                            out_next.result_value    = direct_ok ? head_rec.mantissa : '0;
                            out_next.fraction_digits = !direct_ok ? '0
                                                       : (cfg.fixed_scale_mode
                                                          ? cfg.target_scale
                                                          : head_rec.frac_count);
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        val_next   = head_rec.mantissa;
                        cnt_next   = head_rec.frac_count;
                        ok_next    = 1'b1;
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE:
            begin
                // one multiply by ten per cycle until the scale is reached or the value would overflow
                if (!ok_reg || (cnt_reg >= cfg.target_scale))
                begin
                    if (slot_free)
                    begin
                        load_out                 = 1'b1;
                        out_next.accepted        = ok_reg;
                        out_next.result_value    = ok_reg ? val_reg : '0;
                        out_next.fraction_digits = ok_reg ? cfg.target_scale : '0;
                        state_next               = ST_IDLE;
                    end
                end
                else if (val_reg > dsfp_pkg::MUL10_LIMIT)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    val_next = dsfp_pkg::VALUE_W'((val_reg << 3) + (val_reg << 1));
                    cnt_next = dsfp_pkg::CNT_W'(cnt_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    `DSFP_ASSERT_IMPLIES(a_reject_zero, clk, rst_n, out_valid_reg && !out_reg.accepted, (out_reg.result_value == '0) && (out_reg.fraction_digits == '0))
    `DSFP_ASSERT_IMPLIES(a_pop_only_idle, clk, rst_n, pop, state_reg == ST_IDLE)

endmodule

`default_nettype wire

/* hdl/decimal_string_to_fixed_point.sv */
`timescale 1ns / 1ps
`default_nettype none

// Parses an unsigned decimal string into a 64-bit mantissa. The front
// section takes one character beat per cycle while the queue is not full
// and does the multiply-by-ten-and-add for each digit in that cycle; a
// finished string goes into a two-entry queue. In exponent mode, for
// rejected strings and for fixed-scale strings with at least target_scale
// fraction digits, the back section writes a queued string straight into
// the output register, so strings of any length run at one character per
// cycle while results are taken. Otherwise the back section scales with
// one multiply by ten per cycle; the front keeps taking characters until
// the queue is full. Results sit in an output register, so a stalled
// consumer only stops the block once the queue fills. The user must write
// configuration only while no string is in flight, which is not enforced.
module decimal_string_to_fixed_point #(
    parameter int MAX_LENGTH  = 22,
    parameter int DIGIT_LIMIT = 20
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                char_valid,
    output logic                                     char_ready,
    input  wire dsfp_pkg::char_beat_t                char_data,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output dsfp_pkg::res_beat_t                      res_data,
    input  wire logic                                cfg_we,
    input  wire logic [dsfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dsfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dsfp_pkg::cfg_t      cfg_reg;
    dsfp_pkg::q_status_t q_status;
    dsfp_pkg::str_rec_t  push_rec;
    dsfp_pkg::str_rec_t  head_rec;
    logic                push;
    logic                pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsfp_pkg::CFG_FIXED_SCALE_MODE: cfg_reg.fixed_scale_mode <= cfg_data[0];
                dsfp_pkg::CFG_TARGET_SCALE:     cfg_reg.target_scale     <= cfg_data;
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    dsfp_front #(
        .MAX_LENGTH  (MAX_LENGTH),
        .DIGIT_LIMIT (DIGIT_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .q_status   (q_status),
        .push       (push),
        .push_rec   (push_rec)
    );

    dsfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_status (q_status)
    );

    dsfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .head_rec  (head_rec),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire
